// File: rtl/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

  // Table geometry and field widths.
  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned VAL_W        = 8;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned ENTRY_W      = KEY_W + VAL_W;
  localparam int unsigned TDATA_W      = 48;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // One result transaction, handed from the sequencer to the output register.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [VAL_W-1:0]    value;
  } res_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

endpackage

`default_nettype wire

// File: rtl/kvt_ram.sv
`default_nettype none

module kvt_ram
  import kvt_pkg::*;
#(
  parameter int unsigned WIDTH = ENTRY_W,
  parameter int unsigned DEPTH = CAPACITY_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/kvt_seq.sv
`default_nettype none

module kvt_seq
  import kvt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Request side.
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [MODE_W-1:0]   in_mode_i,
  input  wire logic [KEY_W-1:0]    in_key_i,
  input  wire logic [VAL_W-1:0]    in_value_i,
  // Result side.
  output logic                     res_valid_o,
  input  wire logic                res_ready_i,
  output res_t                     res_o,
  // Entry memory.
  output logic                     ram_we_o,
  output logic [AW-1:0]            ram_waddr_o,
  output logic [ENTRY_W-1:0]       ram_wdata_o,
  output logic                     ram_re_o,
  output logic [AW-1:0]            ram_raddr_o,
  input  wire logic [ENTRY_W-1:0]  ram_rdata_i
);

  state_e            st_q, st_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              rvld_q, rvld_d;
  logic [MODE_W-1:0] mode_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  res_t              res_q, res_d;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_val;
  logic              key_eq;
  logic              val_eq;
  logic              hit;
  logic              in_fire;

  assign rd_key  = ram_rdata_i[KEY_W-1:0];
  assign rd_val  = ram_rdata_i[ENTRY_W-1:KEY_W];
  assign in_fire = in_valid_i && in_ready_o;

  // Shared compare unit: one stored entry against the request per cycle.
  assign key_eq = (rd_key == key_q);
  assign val_eq = (rd_val == val_q);
  always_comb begin
    case (mode_q)
      MODE_INSERT: hit = rvld_q && key_eq;
      MODE_GET:    hit = rvld_q && key_eq;
      MODE_FIND:   hit = rvld_q && val_eq;
      default:     hit = 1'b0;
    endcase
  end

  // Sequencer: issue one read a cycle, compare the entry returned in the cycle after.
  always_comb begin
    st_d        = st_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    rvld_d      = 1'b0;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = ptr_q[AW-1:0];
    ram_waddr_o = cnt_q[AW-1:0];
    ram_wdata_o = {val_q, key_q};
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ptr_d = '0;
          st_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_d.status = (mode_q == MODE_INSERT) ? ST_PRESENT : ST_OK;
          res_d.key    = rd_key;
          res_d.value  = rd_val;
          st_d         = S_DONE;
        end else if (!rvld_q && (ptr_q == cnt_q)) begin
          // Every stored entry has been compared without a match.
          res_d.status = ST_MISS;
          res_d.key    = key_q;
          res_d.value  = '0;
          case (mode_q)
            MODE_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                ram_we_o     = 1'b1;
                cnt_d        = cnt_q + CW'(1);
                res_d.status = ST_OK;
                res_d.value  = val_q;
              end
            end
            MODE_FIND: begin
              res_d.key = '1;
            end
            default: begin
              res_d.key = key_q;
            end
          endcase
          st_d = S_DONE;
        end else if (ptr_q != cnt_q) begin
          ram_re_o = 1'b1;
          ptr_d    = ptr_q + CW'(1);
          rvld_d   = 1'b1;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (st_q == S_IDLE);
  assign res_valid_o = (st_q == S_DONE);
  assign res_o       = res_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ptr_q  <= '0;
      cnt_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ptr_q  <= ptr_d;
      cnt_q  <= cnt_d;
      rvld_q <= rvld_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= in_mode_i;
      key_q  <= in_key_i;
      val_q  <= in_value_i;
    end
    res_q <= res_d;
  end

  // The entry count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Entries are written only at the end of an insert scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (st_q == S_SCAN) && (mode_q == MODE_INSERT) && !rvld_q)
    else $error("entry write outside an insert");

  // The count moves only by one and only with an entry write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("entry count did not follow a write");

  // No read is outstanding when a new transaction starts its scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (st_q == S_SCAN) && !rvld_q && (ptr_q == '0))
    else $error("scan did not start cleanly");

endmodule

`default_nettype wire

// File: rtl/key_value_table_linear.sv
// Channel  Direction  tdata fields (lowest bit first)
// s_axis   in         mode[1:0], key[33:2], value[41:34], zero pad to 48 bits
// m_axis   out        status[1:0], key_out[33:2], value_out[41:34], zero pad to 48 bits
//
// One transaction is taken at a time. Its scan runs over the stored entries,
// with the single compare unit reading one entry per cycle from the entry memory.
// Reset clears the entry count, so the table starts empty; no clearing pass.
// A finished result waits in the output register while the next request is
// scanned; a result stalls the sequencer only while that register is full and not taken.
`default_nettype none

module key_value_table_linear
  import kvt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [TDATA_W-1:0] s_axis_tdata_i,  // mode, key, value
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic      [TDATA_W-1:0] m_axis_tdata_o   // status, key_out, value_out
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               out_vld_q, out_vld_d;
  res_t               out_q;

  kvt_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_mode_i   (s_axis_tdata_i[MODE_W-1:0]),
    .in_key_i    (s_axis_tdata_i[MODE_W+KEY_W-1:MODE_W]),
    .in_value_i  (s_axis_tdata_i[MODE_W+KEY_W+VAL_W-1:MODE_W+KEY_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  kvt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: loads when empty or when its transaction is taken.
  assign res_ready = !out_vld_q || m_axis_tready_i;
  always_comb begin
    out_vld_d = out_vld_q;
    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(TDATA_W - STATUS_W - KEY_W - VAL_W){1'b0}},
                            out_q.value, out_q.key, out_q.status};

endmodule

`default_nettype wire
